### design/integer_literal_to_bytecode_assert.svh
// assertion helpers shared by the parser and the encoder
`ifndef INTEGER_LITERAL_TO_BYTECODE_ASSERT_SVH
`define INTEGER_LITERAL_TO_BYTECODE_ASSERT_SVH

// same-cycle implication
`define ILB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ilb check failed");

// next-cycle implication
`define ILB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ilb check failed");

`endif

### design/ilb_pkg.sv
`timescale 1ns / 1ps

package ilb_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_HEX_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_LETTER_BASE = CHAR_UPPER_A - 8'd10;

    localparam logic [VALUE_W-1:0] SMALL_MAX       = 32'd8;
    localparam logic [BYTE_W-1:0]  LEN_HEADER_BASE = 8'd8;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_DEC    = 3'd3,
        PH_HEX    = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef struct packed {
        logic               neg;
        logic [VALUE_W-1:0] mag;
    } t_token;

endpackage

### design/ilb_parser.sv
`timescale 1ns / 1ps
`include "integer_literal_to_bytecode_assert.svh"

module ilb_parser import ilb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_token_end,
    output logic              o_stall,
    output logic              o_tok_valid,
    output t_token            o_tok,
    input  logic              i_tok_take
);

    logic               r_in_valid;
    logic [CHAR_W-1:0]  r_in_char;
    logic               r_in_end;
    t_phase             r_phase;
    t_phase             n_phase;
    logic               r_neg;
    logic               n_neg;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic               r_tok_valid;
    t_token             r_tok;

    logic               proc;
    logic               is_dec;
    logic               is_hex_letter;
    logic [CHAR_W-1:0]  letter_diff;
    logic [3:0]         digit;
    logic [VALUE_W-1:0] acc_dec;
    logic [VALUE_W-1:0] acc_hex;
    logic [VALUE_W-1:0] acc_first;

    // an end character waits while the previous token is still unclaimed
    assign proc    = r_in_valid && !(r_in_end && r_tok_valid);
    assign o_stall = r_in_valid && !proc;

    assign is_dec        = (r_in_char >= CHAR_ZERO) && (r_in_char <= CHAR_NINE);
    assign is_hex_letter = (r_in_char >= CHAR_UPPER_A) && (r_in_char <= CHAR_UPPER_F);
    assign letter_diff   = r_in_char - HEX_LETTER_BASE;
    assign digit         = is_dec ? r_in_char[3:0] : letter_diff[3:0];

    assign acc_dec   = {r_acc[VALUE_W-4:0], 3'b000} + {r_acc[VALUE_W-2:0], 1'b0}
                     + {{(VALUE_W-4){1'b0}}, digit};
    assign acc_hex   = {r_acc[VALUE_W-5:0], digit};
    assign acc_first = {{(VALUE_W-4){1'b0}}, digit};

    // phase transitions
    always_comb begin
        unique case (r_phase)
            PH_START: begin
                if (r_in_char == CHAR_MINUS) begin
                    n_phase = PH_SIGNED;
                end else if (r_in_char == CHAR_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (is_dec) begin
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_SIGNED: begin
                if (r_in_char == CHAR_ZERO) begin
                    n_phase = PH_ZERO;
                end else if (is_dec) begin
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_ZERO: begin
                if (r_in_char == CHAR_HEX_X) begin
                    n_phase = PH_HEX;
                end else if (is_dec) begin
                    n_phase = PH_DEC;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DEC:  n_phase = is_dec ? PH_DEC : PH_DONE;
            PH_HEX:  n_phase = (is_dec || is_hex_letter) ? PH_HEX : PH_DONE;
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    // sign and accumulator update
    always_comb begin
        n_neg = r_neg;
        n_acc = r_acc;
        unique case (r_phase)
            PH_START: begin
                if (r_in_char == CHAR_MINUS) begin
                    n_neg = 1'b1;
                end else if (is_dec) begin
                    n_acc = acc_first;
                end
            end
            PH_SIGNED: begin
                if (is_dec) begin
                    n_acc = acc_first;
                end
            end
            PH_ZERO, PH_DEC: begin
                if (is_dec) begin
                    n_acc = acc_dec;
                end
            end
            PH_HEX: begin
                if (is_dec || is_hex_letter) begin
                    n_acc = acc_hex;
                end
            end
            default: begin
                n_acc = r_acc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_START;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_tok_valid <= 1'b0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (proc) begin
                if (r_in_end) begin
                    r_phase <= PH_START;
                    r_neg   <= 1'b0;
                    r_acc   <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_acc   <= n_acc;
                end
            end
            if (proc && r_in_end) begin
                r_tok_valid <= 1'b1;
            end else if (i_tok_take) begin
                r_tok_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_char <= i_character;
            r_in_end  <= i_token_end;
        end
        if (proc && r_in_end) begin
            r_tok.neg <= n_neg;
            r_tok.mag <= n_acc;
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

    `ILB_ASSERT_NEXT(a_token_clears_state, proc && r_in_end,
        r_phase == PH_START && r_acc == '0 && !r_neg)
    `ILB_ASSERT_SAME(a_start_unsigned, r_phase == PH_START, !r_neg && r_acc == '0)
    `ILB_ASSERT_SAME(a_sign_only, r_phase == PH_SIGNED, r_neg && r_acc == '0)

endmodule

### design/ilb_encoder.sv
`timescale 1ns / 1ps
`include "integer_literal_to_bytecode_assert.svh"

module ilb_encoder import ilb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok_valid,
    input  t_token            i_tok,
    output logic              o_tok_take,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_code_byte,
    output logic              o_last_byte
);

    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic [VALUE_W-1:0] r_val;
    logic [COUNT_W-1:0] r_rem;

    logic               advance;
    logic               busy;
    logic [VALUE_W-1:0] value;
    logic               is_small;
    logic [COUNT_W-1:0] count;
    logic [BYTE_W-1:0]  header;

    assign advance    = !r_out_valid || !i_stall;
    assign busy       = (r_rem != '0);
    assign o_tok_take = advance && !busy && i_tok_valid;

    assign value    = i_tok.neg ? (VALUE_W'(0) - i_tok.mag) : i_tok.mag;
    assign is_small = (value <= SMALL_MAX);

    // significant little-endian bytes
    always_comb begin
        priority if (value[31:24] != '0) begin
            count = 3'd4;
        end else if (value[23:16] != '0) begin
            count = 3'd3;
        end else if (value[15:8] != '0) begin
            count = 3'd2;
        end else begin
            count = 3'd1;
        end
    end

    assign header = BYTE_W'(count) + LEN_HEADER_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rem       <= '0;
        end else if (advance) begin
            if (busy) begin
                r_out_valid <= 1'b1;
                r_rem       <= r_rem - COUNT_W'(1);
            end else if (i_tok_valid) begin
                r_out_valid <= 1'b1;
                r_rem       <= is_small ? '0 : count;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (busy) begin
                r_out_byte <= r_val[BYTE_W-1:0];
                r_out_last <= (r_rem == COUNT_W'(1));
                r_val      <= {{BYTE_W{1'b0}}, r_val[VALUE_W-1:BYTE_W]};
            end else if (i_tok_valid) begin
                r_out_byte <= is_small ? value[BYTE_W-1:0] : header;
                r_out_last <= is_small;
                r_val      <= value;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_byte = r_out_byte;
    assign o_last_byte = r_out_last;

    `ILB_ASSERT_SAME(a_pending_has_output, r_rem != '0, r_out_valid)
    `ILB_ASSERT_SAME(a_last_ends_burst, r_out_valid && r_out_last, r_rem == '0)
    `ILB_ASSERT_SAME(a_burst_bounded, 1'b1, r_rem <= COUNT_W'(4))

endmodule

### design/integer_literal_to_bytecode.sv
`timescale 1ns / 1ps

// Parses an integer token, one character per transaction, and emits its bytecode: a single
// byte for values 0 to 8, otherwise a length header and up to four little-endian value bytes,
// the last one flagged. One character is taken every cycle unless o_stall is high;
// the parse step (a multiply by ten or sixteen and add) sits between the input register
// and the parser state. A literal's encoding leaves the output register one byte per
// cycle while i_stall is low, as the next token's characters keep streaming in; only a
// token end meeting a previous token that the byte emitter has not yet claimed holds
// the input. The parser registers a finished token, then the encoder its first byte.
module integer_literal_to_bytecode import ilb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CHAR_W-1:0] i_character,
    input  logic              i_token_end,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_code_byte,
    output logic              o_last_byte
);

    logic   tok_valid;
    t_token tok;
    logic   tok_take;

    ilb_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_character (i_character),
        .i_token_end (i_token_end),
        .o_stall     (o_stall),
        .o_tok_valid (tok_valid),
        .o_tok       (tok),
        .i_tok_take  (tok_take)
    );

    ilb_encoder u_encoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (tok_valid),
        .i_tok       (tok),
        .o_tok_take  (tok_take),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_code_byte (o_code_byte),
        .o_last_byte (o_last_byte)
    );

endmodule
